>>> rtl/response_line_classifier_macros.svh
// Assertion macros shared by the checker of the response line classifier.
`ifndef RESPONSE_LINE_CLASSIFIER_MACROS_SVH
`define RESPONSE_LINE_CLASSIFIER_MACROS_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define RLC_ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("response_line_classifier: same-cycle check failed");

// Next-cycle implication, checked on every clock edge outside reset.
`define RLC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("response_line_classifier: next-cycle check failed");

`endif

>>> rtl/rlc_pkg.sv
// Types, constants and the keyword rule table of the response line classifier.
package rlc_pkg;

    localparam int LINE_MAX = 63;
    localparam int DEPTH    = 63;
    localparam int ADDR_W   = 6;

    localparam logic [7:0] CHAR_CR = 8'h0d;
    localparam logic [7:0] CHAR_LF = 8'h0a;
    localparam logic [7:0] CHAR_NUL = 8'h00;

    typedef logic [ADDR_W-1:0] t_pos;
    typedef logic [3:0]        t_code;
    typedef logic [3:0]        t_rule;

    localparam t_code CODE_OK       = 4'd0;
    localparam t_code CODE_ERROR    = 4'd1;
    localparam t_code CODE_DEBUG    = 4'd2;
    localparam t_code CODE_IPADDR   = 4'd3;
    localparam t_code CODE_AP       = 4'd4;
    localparam t_code CODE_MODE     = 4'd5;
    localparam t_code CODE_TIME     = 4'd6;
    localparam t_code CODE_WEATHER  = 4'd7;
    localparam t_code CODE_FIRMWARE = 4'd8;
    localparam t_code CODE_CMD      = 4'd9;
    localparam t_code CODE_UNSPEC   = 4'd10;

    localparam t_rule RULE_DOT      = 4'd0;
    localparam t_rule RULE_OK       = 4'd1;
    localparam t_rule RULE_ERROR    = 4'd2;
    localparam t_rule RULE_DEBUG    = 4'd3;
    localparam t_rule RULE_IPADDR   = 4'd4;
    localparam t_rule RULE_AP       = 4'd5;
    localparam t_rule RULE_MODE     = 4'd6;
    localparam t_rule RULE_TIME     = 4'd7;
    localparam t_rule RULE_WEATHER  = 4'd8;
    localparam t_rule RULE_FIRMWARE = 4'd9;
    localparam t_rule RULE_CMD      = 4'd10;
    localparam t_rule RULE_AP_FLAG  = 4'd11;

    // Keyword text is right-justified: the first character sits highest.
    typedef struct packed {
        logic [79:0] text;
        logic [3:0]  start;
        logic [3:0]  len;
        logic        exact;
        t_code       code;
        logic        has_payload;
    } t_rule_info;

    typedef struct packed {
        logic       fits;
        logic       char_eq;
        logic       at_end;
        t_pos       end_pos;
        t_pos       start_pos;
        t_code      code;
        logic       has_payload;
    } t_match;

    typedef struct packed {
        t_code      line_code;
        logic       mode_is_ap;
        logic [7:0] payload_byte;
        logic       payload_valid;
        logic       last_of_line;
    } t_result;

    function automatic t_rule_info rule_info(t_rule r);
        t_rule_info ri;
        ri.text        = '0;
        ri.start       = 4'd0;
        ri.len         = 4'd1;
        ri.exact       = 1'b0;
        ri.code        = CODE_UNSPEC;
        ri.has_payload = 1'b0;
        case (r)
            RULE_DOT: begin
                ri.text = 80'("."); ri.len = 4'd1; ri.exact = 1'b1; ri.code = CODE_OK;
            end
            RULE_OK: begin
                ri.text = 80'("OK"); ri.len = 4'd2; ri.code = CODE_OK;
            end
            RULE_ERROR: begin
                ri.text = 80'("ERROR"); ri.len = 4'd5; ri.code = CODE_ERROR;
            end
            RULE_DEBUG: begin
                ri.text = 80'("- "); ri.len = 4'd2; ri.code = CODE_DEBUG;
            end
            RULE_IPADDR: begin
                ri.text = 80'("IPADDRESS "); ri.len = 4'd10; ri.code = CODE_IPADDR;
                ri.has_payload = 1'b1;
            end
            RULE_AP: begin
                ri.text = 80'("AP "); ri.len = 4'd3; ri.code = CODE_AP;
                ri.has_payload = 1'b1;
            end
            RULE_MODE: begin
                ri.text = 80'("MODE "); ri.len = 4'd5; ri.code = CODE_MODE;
            end
            RULE_TIME: begin
                ri.text = 80'("TIME "); ri.len = 4'd5; ri.code = CODE_TIME;
                ri.has_payload = 1'b1;
            end
            RULE_WEATHER: begin
                ri.text = 80'("WEATHER "); ri.len = 4'd8; ri.code = CODE_WEATHER;
                ri.has_payload = 1'b1;
            end
            RULE_FIRMWARE: begin
                ri.text = 80'("FIRMWARE "); ri.len = 4'd9; ri.code = CODE_FIRMWARE;
                ri.has_payload = 1'b1;
            end
            RULE_CMD: begin
                ri.text = 80'("CMD "); ri.len = 4'd4; ri.code = CODE_CMD;
                ri.has_payload = 1'b1;
            end
            RULE_AP_FLAG: begin
                ri.text = 80'("ap"); ri.start = 4'd5; ri.len = 4'd2; ri.code = CODE_MODE;
            end
            default: begin
                ri.exact = 1'b1;
            end
        endcase
        return ri;
    endfunction

endpackage

>>> rtl/rlc_line_ram.sv
// Line store: one write port for incoming bytes, one registered read port.
module rlc_line_ram (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  rlc_pkg::t_pos     i_wr_addr,
    input  logic [7:0]        i_wr_data,
    input  rlc_pkg::t_pos     i_rd_addr,
    output logic [7:0]        o_rd_data
);
    import rlc_pkg::*;

    logic [7:0] r_mem [0:DEPTH-1];
    logic [7:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> rtl/rlc_match.sv
// Shared keyword compare unit: rule lookup, length check and one byte compare.
module rlc_match (
    input  rlc_pkg::t_rule    i_rule,
    input  rlc_pkg::t_pos     i_pos,
    input  logic [7:0]        i_rd_data,
    input  rlc_pkg::t_pos     i_text_len,
    output rlc_pkg::t_match   o_match
);
    import rlc_pkg::*;

    t_rule_info info;
    t_pos       end_pos;
    t_pos       start_pos;
    logic [3:0] k;
    logic [3:0] idx;
    logic [6:0] sh;

    always_comb begin
        info      = rule_info(i_rule);
        start_pos = {2'b00, info.start};
        end_pos   = start_pos + {2'b00, info.len};
        k         = 4'(i_pos - start_pos);
        idx       = info.len - 4'd1 - k;
        sh        = {idx, 3'b000};

        o_match.fits        = info.exact ? (i_text_len == 6'd1) : (end_pos <= i_text_len);
        o_match.char_eq     = (i_rd_data == info.text[sh +: 8]);
        o_match.at_end      = (i_pos == end_pos - 6'd1);
        o_match.end_pos     = end_pos;
        o_match.start_pos   = start_pos;
        o_match.code        = info.code;
        o_match.has_payload = info.has_payload;
    end

endmodule

>>> rtl/rlc_out_reg.sv
// Result output register with valid and stall.
module rlc_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  rlc_pkg::t_result  i_result,
    output logic              o_can_load,
    input  logic              i_stall,
    output logic              o_valid,
    output rlc_pkg::t_result  o_result
);
    import rlc_pkg::*;

    logic    r_valid;
    logic    n_valid;
    t_result r_result;

    assign o_can_load = !r_valid || !i_stall;

    always_comb begin
        n_valid = r_valid;
        if (o_can_load) begin
            n_valid = i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        if (i_load && o_can_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

>>> rtl/rlc_seq.sv
// Line intake and classification sequencer driving the shared compare unit.
module rlc_seq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_rx_valid,
    output logic              o_rx_stall,
    input  logic [7:0]        i_rx_byte,
    output logic              o_wr_en,
    output rlc_pkg::t_pos     o_wr_addr,
    output logic [7:0]        o_wr_data,
    output rlc_pkg::t_pos     o_rd_addr,
    input  logic [7:0]        i_rd_data,
    input  logic              i_can_load,
    output logic              o_load,
    output rlc_pkg::t_result  o_result
);
    import rlc_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE    = 6'b000001,
        S_CHECK   = 6'b000010,
        S_RD      = 6'b000100,
        S_CMP     = 6'b001000,
        S_EMIT_RD = 6'b010000,
        S_EMIT    = 6'b100000
    } t_state;

    t_state r_state, n_state;
    t_pos   r_len, n_len;
    t_pos   r_text_len, n_text_len;
    logic   r_zero_seen, n_zero_seen;
    t_pos   r_scan_len, n_scan_len;
    t_rule  r_rule, n_rule;
    t_pos   r_pos, n_pos;
    t_code  r_code, n_code;
    logic   r_has_pl, n_has_pl;
    logic   r_ap, n_ap;
    t_match m;
    logic   accept;
    logic   go_emit;
    t_pos   em_start;
    logic   em_hp;
    logic   rule_fail;
    logic   rule_pass;

    rlc_match u_match (
        .i_rule     (r_rule),
        .i_pos      (r_pos),
        .i_rd_data  (i_rd_data),
        .i_text_len (r_scan_len),
        .o_match    (m)
    );

    assign o_rx_stall = (r_state != S_IDLE);
    assign accept     = i_rx_valid && (r_state == S_IDLE);
    assign o_wr_addr  = r_len;
    assign o_wr_data  = i_rx_byte;
    assign o_wr_en    = accept && (i_rx_byte != CHAR_CR) && (i_rx_byte != CHAR_LF)
                        && (r_len < t_pos'(LINE_MAX));
    assign o_rd_addr  = r_pos;

    always_comb begin
        n_state     = r_state;
        n_len       = r_len;
        n_text_len  = r_text_len;
        n_zero_seen = r_zero_seen;
        n_scan_len  = r_scan_len;
        n_rule      = r_rule;
        n_pos       = r_pos;
        n_code      = r_code;
        n_has_pl    = r_has_pl;
        n_ap        = r_ap;
        go_emit     = 1'b0;
        em_start    = '0;
        em_hp       = 1'b0;
        rule_fail   = 1'b0;
        rule_pass   = 1'b0;
        o_load      = 1'b0;

        o_result.line_code     = r_code;
        o_result.mode_is_ap    = r_has_pl ? 1'b0 : r_ap;
        o_result.payload_byte  = r_has_pl ? i_rd_data : 8'h00;
        o_result.payload_valid = r_has_pl;
        o_result.last_of_line  = r_has_pl ? (r_pos == r_scan_len - 6'd1) : 1'b1;

        case (r_state)
            S_IDLE: begin
                if (accept && (i_rx_byte == CHAR_LF)) begin
                    n_len       = '0;
                    n_text_len  = '0;
                    n_zero_seen = 1'b0;
                    if (r_len != '0) begin
                        n_scan_len = r_text_len;
                        n_rule     = RULE_DOT;
                        n_code     = CODE_UNSPEC;
                        n_has_pl   = 1'b0;
                        n_ap       = 1'b0;
                        n_state    = S_CHECK;
                    end
                end else if (o_wr_en) begin
                    n_len = r_len + 6'd1;
                    if (!r_zero_seen) begin
                        if (i_rx_byte == CHAR_NUL) begin
                            n_zero_seen = 1'b1;
                        end else begin
                            n_text_len = r_text_len + 6'd1;
                        end
                    end
                end
            end
            S_CHECK: begin
                if (m.fits) begin
                    n_pos   = m.start_pos;
                    n_state = S_RD;
                end else begin
                    rule_fail = 1'b1;
                end
            end
            S_RD: begin
                n_state = S_CMP;
            end
            S_CMP: begin
                if (!m.char_eq) begin
                    rule_fail = 1'b1;
                end else if (m.at_end) begin
                    rule_pass = 1'b1;
                end else begin
                    n_pos   = r_pos + 6'd1;
                    n_state = S_RD;
                end
            end
            S_EMIT_RD: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (i_can_load) begin
                    o_load = 1'b1;
                    if (o_result.last_of_line) begin
                        n_state = S_IDLE;
                    end else begin
                        n_pos   = r_pos + 6'd1;
                        n_state = S_EMIT_RD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (rule_fail) begin
            if (r_rule == RULE_AP_FLAG) begin
                n_ap    = 1'b0;
                go_emit = 1'b1;
            end else if (r_rule == RULE_CMD) begin
                n_code  = CODE_UNSPEC;
                go_emit = 1'b1;
            end else begin
                n_rule  = r_rule + 4'd1;
                n_state = S_CHECK;
            end
        end

        if (rule_pass) begin
            if (r_rule == RULE_AP_FLAG) begin
                n_ap    = 1'b1;
                go_emit = 1'b1;
            end else if (r_rule == RULE_MODE) begin
                n_code  = m.code;
                n_rule  = RULE_AP_FLAG;
                n_state = S_CHECK;
            end else begin
                n_code   = m.code;
                em_start = m.end_pos;
                em_hp    = m.has_payload;
                go_emit  = 1'b1;
            end
        end

        if (go_emit) begin
            n_pos    = em_start;
            n_has_pl = em_hp && (em_start < r_scan_len);
            n_state  = S_EMIT_RD;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_len       <= '0;
            r_text_len  <= '0;
            r_zero_seen <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_len       <= n_len;
            r_text_len  <= n_text_len;
            r_zero_seen <= n_zero_seen;
        end
        r_scan_len <= n_scan_len;
        r_rule     <= n_rule;
        r_pos      <= n_pos;
        r_code     <= n_code;
        r_has_pl   <= n_has_pl;
        r_ap       <= n_ap;
    end

endmodule

>>> rtl/response_line_classifier.sv
// Top level of the response line classifier.
//
//   channel  direction  handshake              payload
//   rx       in         i_rx_valid/o_rx_stall  i_rx_byte
//   res      out        o_res_valid/i_res_stall o_line_code, o_mode_is_ap, o_payload_byte,
//                                              o_payload_valid, o_last_of_line
//
// Bytes other than CR and LF are written to the line store up to 63 bytes per line.
// A line feed ending a non-empty line starts the sequencer: each keyword rule takes a
// length check, then per compared character a read on the registered port of the line
// store and a compare on the shared unit; each result then takes a read and an emit step.
// Reset clears the line length and the output valid; the line store is not cleared.
// The rx side is stalled while a line is classified or emitted; a stalled result
// holds the sequencer, and bytes are taken while the last result still waits.
module response_line_classifier (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_rx_valid,
    output logic        o_rx_stall,
    input  logic [7:0]  i_rx_byte,
    output logic        o_res_valid,
    input  logic        i_res_stall,
    output logic [3:0]  o_line_code,
    output logic        o_mode_is_ap,
    output logic [7:0]  o_payload_byte,
    output logic        o_payload_valid,
    output logic        o_last_of_line
);
    import rlc_pkg::*;

    logic       wr_en;
    t_pos       wr_addr;
    logic [7:0] wr_data;
    t_pos       rd_addr;
    logic [7:0] rd_data;
    logic       can_load;
    logic       load;
    t_result    seq_result;
    t_result    out_result;

    rlc_line_ram u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    rlc_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rx_valid (i_rx_valid),
        .o_rx_stall (o_rx_stall),
        .i_rx_byte  (i_rx_byte),
        .o_wr_en    (wr_en),
        .o_wr_addr  (wr_addr),
        .o_wr_data  (wr_data),
        .o_rd_addr  (rd_addr),
        .i_rd_data  (rd_data),
        .i_can_load (can_load),
        .o_load     (load),
        .o_result   (seq_result)
    );

    rlc_out_reg u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (load),
        .i_result   (seq_result),
        .o_can_load (can_load),
        .i_stall    (i_res_stall),
        .o_valid    (o_res_valid),
        .o_result   (out_result)
    );

    assign o_line_code     = out_result.line_code;
    assign o_mode_is_ap    = out_result.mode_is_ap;
    assign o_payload_byte  = out_result.payload_byte;
    assign o_payload_valid = out_result.payload_valid;
    assign o_last_of_line  = out_result.last_of_line;

endmodule

>>> rtl/rlc_checker.sv
// Port-level checker of the response line classifier and its bind.
`include "response_line_classifier_macros.svh"

module rlc_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_rx_valid,
    input  logic        o_rx_stall,
    input  logic [7:0]  i_rx_byte,
    input  logic        o_res_valid,
    input  logic        i_res_stall,
    input  logic [3:0]  o_line_code,
    input  logic        o_mode_is_ap,
    input  logic [7:0]  o_payload_byte,
    input  logic        o_payload_valid,
    input  logic        o_last_of_line
);
    import rlc_pkg::*;

    `RLC_ASSERT_NEXT(a_rx_hold, i_rx_valid && o_rx_stall, i_rx_valid && $stable(i_rx_byte))
    `RLC_ASSERT_NEXT(a_res_hold, o_res_valid && i_res_stall, o_res_valid && $stable(o_line_code) && $stable(o_payload_byte) && $stable(o_last_of_line))
    `RLC_ASSERT_IMPLY(a_code_only_last, o_res_valid && !o_payload_valid, o_last_of_line && (o_payload_byte == 8'h00))
    `RLC_ASSERT_IMPLY(a_ap_on_mode, o_res_valid && o_mode_is_ap, (o_line_code == CODE_MODE) && !o_payload_valid)
    `RLC_ASSERT_IMPLY(a_code_range, o_res_valid, o_line_code <= CODE_UNSPEC)

endmodule

bind response_line_classifier rlc_checker u_rlc_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_rx_valid      (i_rx_valid),
    .o_rx_stall      (o_rx_stall),
    .i_rx_byte       (i_rx_byte),
    .o_res_valid     (o_res_valid),
    .i_res_stall     (i_res_stall),
    .o_line_code     (o_line_code),
    .o_mode_is_ap    (o_mode_is_ap),
    .o_payload_byte  (o_payload_byte),
    .o_payload_valid (o_payload_valid),
    .o_last_of_line  (o_last_of_line)
);

>>> dv/tb_top.sv
// Testbench of the response line classifier: queued serial bytes, line prediction, result checks.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import rlc_pkg::*;

    localparam int ITEMS_TARGET   = 410;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 300;
    localparam int REPORT_LIMIT   = 10;

    logic       i_clk   = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_rx_valid = 1'b0;
    logic [7:0] i_rx_byte  = 8'h00;
    logic       i_res_stall = 1'b0;
    logic       o_rx_stall;
    logic       o_res_valid;
    logic [3:0] o_line_code;
    logic       o_mode_is_ap;
    logic [7:0] o_payload_byte;
    logic       o_payload_valid;
    logic       o_last_of_line;

    logic [7:0] rx_bytes_q[$];
    t_result    expected_results[$];

    logic [7:0] line_buf [DEPTH];
    int         line_len      = 0;
    bit         line_clipped  = 1'b0;
    int         lines_seen    = 0;
    int         clipped_lines = 0;
    logic [10:0] kinds_seen   = '0;

    int  total_items  = 0;
    int  rx_count     = 0;
    int  res_count    = 0;
    int  fail_count   = 0;
    int  hold_left    = 0;
    int  holds_done   = 0;
    int  quiet_cycles = 0;
    bit  rx_taken     = 1'b0;

    response_line_classifier u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_rx_valid      (i_rx_valid),
        .o_rx_stall      (o_rx_stall),
        .i_rx_byte       (i_rx_byte),
        .o_res_valid     (o_res_valid),
        .i_res_stall     (i_res_stall),
        .o_line_code     (o_line_code),
        .o_mode_is_ap    (o_mode_is_ap),
        .o_payload_byte  (o_payload_byte),
        .o_payload_valid (o_payload_valid),
        .o_last_of_line  (o_last_of_line)
    );

    always #6 i_clk = ~i_clk;

    function automatic string keyword_of(t_code c);
        case (c)
            CODE_OK:       return "OK";
            CODE_ERROR:    return "ERROR";
            CODE_DEBUG:    return "- ";
            CODE_IPADDR:   return "IPADDRESS ";
            CODE_AP:       return "AP ";
            CODE_MODE:     return "MODE ";
            CODE_TIME:     return "TIME ";
            CODE_WEATHER:  return "WEATHER ";
            CODE_FIRMWARE: return "FIRMWARE ";
            CODE_CMD:      return "CMD ";
            default:       return "";
        endcase
    endfunction

    function automatic bit text_has(int from, int text_len, string kw);
        int i;
        if (from + kw.len() > text_len) return 1'b0;
        for (i = 0; i < kw.len(); i++) begin
            if (line_buf[from + i] != kw[i]) return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic void predict_rx_byte(logic [7:0] b);
        int      n_len;
        int      text_len;
        int      first;
        int      i;
        t_code   code;
        t_code   c;
        logic    ap;
        bit      found;
        bit      carries;
        t_result r;
        if (b == CHAR_CR) return;
        if (b != CHAR_LF) begin
            if (line_len < LINE_MAX) begin
                line_buf[line_len] = b;
                line_len++;
            end else begin
                line_clipped = 1'b1;
            end
            return;
        end
        n_len    = line_len;
        line_len = 0;
        if (line_clipped) clipped_lines++;
        line_clipped = 1'b0;
        if (n_len == 0) return;
        lines_seen++;
        text_len = 0;
        while (text_len < n_len && line_buf[text_len] != CHAR_NUL) text_len++;
        code    = CODE_UNSPEC;
        ap      = 1'b0;
        first   = 0;
        carries = 1'b0;
        found   = 1'b0;
        if (text_len == 1 && line_buf[0] == ".") begin
            code = CODE_OK;
        end else begin
            for (c = CODE_OK; c <= CODE_CMD && !found; c++) begin
                if (text_has(0, text_len, keyword_of(c))) begin
                    found = 1'b1;
                    code  = c;
                    first = keyword_of(c).len();
                    case (c)
                        CODE_IPADDR, CODE_AP, CODE_TIME, CODE_WEATHER, CODE_FIRMWARE,
                        CODE_CMD: carries = 1'b1;
                        default:  carries = 1'b0;
                    endcase
                    if (c == CODE_MODE) ap = text_has(first, text_len, "ap");
                end
            end
        end
        kinds_seen[code] = 1'b1;
        if (!carries || first >= text_len) begin
            r.line_code     = code;
            r.mode_is_ap    = ap;
            r.payload_byte  = 8'h00;
            r.payload_valid = 1'b0;
            r.last_of_line  = 1'b1;
            expected_results.push_back(r);
            return;
        end
        for (i = first; i < text_len; i++) begin
            r.line_code     = code;
            r.mode_is_ap    = 1'b0;
            r.payload_byte  = line_buf[i];
            r.payload_valid = 1'b1;
            r.last_of_line  = (i + 1 == text_len);
            expected_results.push_back(r);
        end
    endfunction

    function automatic void queue_text(string s);
        int i;
        for (i = 0; i < s.len(); i++) rx_bytes_q.push_back(s[i]);
    endfunction

    function automatic logic [7:0] random_text_byte();
        if ($urandom_range(0, 4) == 0) return 8'($urandom_range(0, 255));
        return 8'($urandom_range(8'h20, 8'h7e));
    endfunction

    function automatic int idle_pct(bit for_receiver);
        int ph;
        ph = (total_items == 0) ? 0 : rx_count * 4 / total_items;
        case (ph)
            1:       return for_receiver ? 0 : 62;
            2:       return for_receiver ? 62 : 0;
            3:       return 20;
            default: return 0;
        endcase
    endfunction

    always @(negedge i_clk) begin
        if (i_rst_n && (!i_rx_valid || rx_taken)) begin
            if (rx_bytes_q.size() != 0 && $urandom_range(0, 99) >= idle_pct(1'b0)) begin
                i_rx_valid <= 1'b1;
                i_rx_byte  <= rx_bytes_q.pop_front();
            end else begin
                i_rx_valid <= 1'b0;
            end
        end
    end

    // The receiver holds off twice early in the run while the sender keeps offering bytes.
    always @(negedge i_clk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (holds_done < 2 && rx_count >= 30 + 50 * holds_done) begin
            hold_left  <= HOLD_CYCLES;
            holds_done <= holds_done + 1;
        end
    end

    always @(negedge i_clk) begin
        i_res_stall <= (hold_left != 0) || ($urandom_range(0, 99) < idle_pct(1'b1));
    end

    always @(posedge i_clk) begin : monitor
        t_result want;
        rx_taken <= i_rst_n && i_rx_valid && !o_rx_stall;
        if (i_rst_n && i_rx_valid && !o_rx_stall) begin
            rx_count++;
            predict_rx_byte(i_rx_byte);
        end
        if (i_rst_n && o_res_valid && !i_res_stall) begin
            res_count++;
            if (expected_results.size() == 0) begin
                fail_count++;
                if (fail_count <= REPORT_LIMIT)
                    $display("unexpected result transfer: code %0d byte %02h valid %0b last %0b",
                             o_line_code, o_payload_byte, o_payload_valid, o_last_of_line);
            end else begin
                want = expected_results.pop_front();
                if (o_line_code !== want.line_code || o_mode_is_ap !== want.mode_is_ap ||
                    o_payload_byte !== want.payload_byte ||
                    o_payload_valid !== want.payload_valid ||
                    o_last_of_line !== want.last_of_line) begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT) begin
                        $display("result %0d: expected code %0d ap %0b byte %02h valid %0b last %0b",
                                 res_count, want.line_code, want.mode_is_ap, want.payload_byte,
                                 want.payload_valid, want.last_of_line);
                        $display("result %0d:      got code %0d ap %0b byte %02h valid %0b last %0b",
                                 res_count, o_line_code, o_mode_is_ap, o_payload_byte,
                                 o_payload_valid, o_last_of_line);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_rx_valid && !o_rx_stall) || (o_res_valid && !i_res_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
                     WATCHDOG_LIMIT, expected_results.size());
            $display("tb_top: FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int    sel;
        int    plen;
        int    k;
        int    i;
        bit    cut;
        t_code c;
        string kw;

        queue_text(".\n");
        queue_text("\n");
        rx_bytes_q.push_back(CHAR_NUL);
        queue_text("\n");
        queue_text("OK\r\n");
        queue_text("CMD ");
        rx_bytes_q.push_back(8'hff);
        queue_text("\n");
        queue_text("MODE ap\n");

        while (rx_bytes_q.size() < ITEMS_TARGET) begin
            sel  = $urandom_range(0, 99);
            c    = t_code'($urandom_range(CODE_OK, CODE_CMD));
            kw   = keyword_of(c);
            plen = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 70) : $urandom_range(0, 10);
            if (sel < 65) begin
                queue_text(kw);
                if (c == CODE_MODE) begin
                    case ($urandom_range(0, 3))
                        0:       queue_text("ap");
                        1:       queue_text("a");
                        2:       queue_text("client");
                        default: ;
                    endcase
                end
            end else if (sel < 72) begin
                queue_text(".");
                plen = $urandom_range(0, 1);
            end else if (sel < 85) begin
                k   = $urandom_range(1, kw.len() - 1);
                cut = $urandom_range(0, 1);
                for (i = 0; i < (cut ? k : kw.len()); i++)
                    rx_bytes_q.push_back((i == k && !cut) ? (kw[i] ^ 8'h01) : kw[i]);
            end else if (sel < 92) begin
                plen = 0;
            end else begin
                plen = $urandom_range(1, 8);
                for (i = 0; i < plen; i++) rx_bytes_q.push_back(8'($urandom_range(0, 255)));
                plen = 0;
            end
            for (i = 0; i < plen; i++) rx_bytes_q.push_back(random_text_byte());
            if ($urandom_range(0, 9) < 3) queue_text("\r");
            queue_text("\n");
        end
        total_items = rx_bytes_q.size();

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (rx_bytes_q.size() != 0 || i_rx_valid) @(posedge i_clk);
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("summary: %0d bytes in %0d lines, %0d of 11 line kinds, %0d lines clipped",
                 rx_count, lines_seen, $countones(kinds_seen), clipped_lines);
        $display("summary: %0d result transfers checked, %0d failures", res_count, fail_count);
        if (fail_count == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule
